// File: hw/rtl/cms_pkg.sv
package cms_pkg;

   localparam int unsigned FREQ_W  = 32;
   localparam int unsigned SHIFT_W = 6;
   localparam int unsigned QUOT_W  = 2 * FREQ_W;
   localparam int unsigned CNT_W   = $clog2(QUOT_W);

   localparam logic [SHIFT_W-1:0] ACC_START   = SHIFT_W'(FREQ_W);
   localparam logic [SHIFT_W-1:0] SHIFT_START = SHIFT_W'(FREQ_W);
   localparam logic [SHIFT_W-1:0] SHIFT_LAST  = SHIFT_W'(1);
   localparam logic [CNT_W-1:0]   DIV_LAST    = CNT_W'(QUOT_W - 1);

   typedef struct packed {
      logic [FREQ_W-1:0] source_hz;
      logic [FREQ_W-1:0] target_hz;
      logic [FREQ_W-1:0] max_span_sec;
   } req_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  multiplier;
      logic [SHIFT_W-1:0] shift_amount;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_SETUP,
      ST_DIV,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

// File: hw/rtl/clock_mult_shift_calculator.sv
// Sequence: a zero source frequency goes straight to the done state; otherwise the
//   sequencer first finds L (0..32), the bit length of the span product's upper word, then
//   runs T (1..32) trial shifts, each one 64-step restoring division.
// Flow: one request at a time; req_ready is high only in the idle state, and
//   a finished result waits in the output register while the next beat is taken.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module clock_mult_shift_calculator
   import cms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;

   logic [FREQ_W-1:0]  src_ff, src_in;
   logic [FREQ_W-1:0]  tgt_ff, tgt_in;
   logic [FREQ_W-1:0]  hi_ff, hi_in;
   logic [SHIFT_W-1:0] budget_ff, budget_in;
   logic [SHIFT_W-1:0] sft_ff, sft_in;
   logic [QUOT_W-1:0]  num_ff, num_in;
   logic [FREQ_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               out_free;
   logic [QUOT_W-1:0]  span_prod;
   logic [FREQ_W:0]    rem_shift;
   logic [FREQ_W+1:0]  diff;
   logic               q_bit;
   logic               fits;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // span times source; only the upper word sets the budget
   assign span_prod = QUOT_W'(req_data.max_span_sec) * QUOT_W'(req_data.source_hz);

   // shared subtractor: one restoring division step
   assign rem_shift = {rem_ff, num_ff[QUOT_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, src_ff};
   assign q_bit     = ~diff[FREQ_W+1];

   // quotient fits the accuracy budget
   assign fits = ((quot_ff >> budget_ff) == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.source_hz == '0) ? ST_DONE : ST_LEN;
            end
         end
         ST_LEN: begin
            if (hi_ff == '0) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fits || sft_ff == SHIFT_LAST) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      hi_in        = hi_ff;
      budget_in    = budget_ff;
      sft_in       = sft_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               src_in    = req_data.source_hz;
               tgt_in    = req_data.target_hz;
               hi_in     = span_prod[QUOT_W-1:FREQ_W];
               budget_in = ACC_START;
               quot_in   = '0;
               sft_in    = (req_data.source_hz == '0) ? '0 : SHIFT_START;
            end
         end
         ST_LEN: begin
            // drop one budget bit per significant bit of the span word
            if (hi_ff != '0) begin
               hi_in     = hi_ff >> 1;
               budget_in = budget_ff - SHIFT_W'(1);
            end
         end
         ST_SETUP: begin
            // rounded numerator for this trial shift
            num_in = (QUOT_W'(tgt_ff) << sft_ff) + QUOT_W'(src_ff[FREQ_W-1:1]);
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            num_in  = num_ff << 1;
            rem_in  = q_bit ? diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], q_bit};
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         ST_CHECK: begin
            if (!fits) begin
               sft_in = (sft_ff == SHIFT_LAST) ? '0 : sft_ff - SHIFT_W'(1);
            end
         end
         ST_DONE: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_in.multiplier   = quot_ff[FREQ_W-1:0];
               rsp_in.shift_amount = sft_ff;
               rsp_valid_in        = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff    <= src_in;
      tgt_ff    <= tgt_in;
      hi_ff     <= hi_in;
      budget_ff <= budget_in;
      sft_ff    <= sft_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// File: hw/rtl/cms_checker.sv
module cms_checker
   import cms_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // one item at a time: ready drops after an accepted beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // shift never exceeds its start value
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.shift_amount <= SHIFT_START)
      else $error("shift out of range");

   // idle right after reset: no result, and ready for a request
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind clock_mult_shift_calculator cms_checker u_cms_checker (.*);
